/* rtl/rmh_pkg.sv */
// ----------------------------------------------------------------------------
// Running median package
// Shared widths, default depth and sequencer encodings for the two-heap
// running median block.
// ----------------------------------------------------------------------------
package rmh_pkg;

    // Widths fixed by the word format.
    localparam int SAMPLE_W = 32;
    localparam int MED_W    = 33;
    localparam int CNT_W    = 10;

    // Default number of entries in each heap store.
    localparam int HEAP_DEPTH_DEF = 512;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_TOPCMP,
        S_UP,
        S_UPCMP,
        S_AFTER,
        S_POP0,
        S_POP1,
        S_DN,
        S_DNL,
        S_DNR,
        S_DNC,
        S_MED,
        S_MED1,
        S_OUT
    } state_t;

    // Which heap operation has just finished.
    typedef enum logic [1:0] {
        PH_INS,
        PH_POP,
        PH_MOVE
    } phase_t;

endpackage

/* rtl/rmh_in_if.sv */
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one sample word and its restart flag.
// ----------------------------------------------------------------------------
interface rmh_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  sample;
    logic                start_new;

    modport source (output valid, output sample, output start_new, input ready);
    modport sink   (input valid, input sample, input start_new, output ready);
endinterface

/* rtl/rmh_out_if.sv */
// ----------------------------------------------------------------------------
// Median channel
// Valid/ready channel that carries one median result word.
// ----------------------------------------------------------------------------
interface rmh_out_if;
    logic                valid;
    logic                ready;
    logic signed [32:0]  median_doubled;
    logic [9:0]          held_count;
    logic                rejected;

    modport source (output valid, output median_doubled, output held_count,
                    output rejected, input ready);
    modport sink   (input valid, input median_doubled, input held_count,
                    input rejected, output ready);
endinterface

/* rtl/rmh_ram.sv */
// ----------------------------------------------------------------------------
// Heap store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module rmh_ram
    import rmh_pkg::*;
#(
    parameter int DEPTH = HEAP_DEPTH_DEF,
    parameter int WIDTH = SAMPLE_W
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/rmh_cmp.sv */
// ----------------------------------------------------------------------------
// Heap order compare unit
// Tells whether key a outranks key b: greater for a max-heap, less for a
// min-heap. Equal keys never outrank each other.
// ----------------------------------------------------------------------------
module rmh_cmp
    import rmh_pkg::*;
(
    input  logic                       is_max,
    input  logic signed [SAMPLE_W-1:0] a,
    input  logic signed [SAMPLE_W-1:0] b,
    output logic                       outranks
);

    always_comb
    begin
        outranks = is_max ? (a > b) : (a < b);
    end

endmodule

/* rtl/running_median_two_heaps.sv */
// ----------------------------------------------------------------------------
// Running median over two heaps
// Keeps the lower half of the samples in a max-heap and the upper half in a
// min-heap and returns twice the median after every sample.
// ----------------------------------------------------------------------------
// Usage:
// A sample word enters on the samples channel. One result word leaves on the
// results channel for each sample: twice the median, the number of samples
// held and a rejected flag. A sample with start_new set empties both heaps
// first. When the heaps together hold 2*HEAP_DEPTH-1 samples, the sample is
// dropped, rejected is set and the last median is repeated.
// One sample is processed at a time; samples.ready is low from acceptance
// until its result is taken. A sample that finds the store full goes straight
// to the result. Otherwise the time a sample takes grows with the levels that
// the insert walk climbs and, when the heaps must be rebalanced, with the
// levels of the removal walk and of a second insert walk. It is set by the
// single read port of each heap store and the shared compare unit.
// Reset empties both heaps and clears the last median to zero. The stores
// need no clearing pass. A result waits in the output register for as long
// as results.ready is low; no further sample is taken meanwhile.
// ----------------------------------------------------------------------------
module running_median_two_heaps
    import rmh_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    rmh_in_if.sink       samples,
    rmh_out_if.source    results
);

    localparam int SW = $clog2(HEAP_DEPTH + 1);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam logic [SW:0] FULL_CNT = (SW+1)'(2 * HEAP_DEPTH - 1);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [SW-1:0] lsize_reg, lsize_next;
    logic [SW-1:0] usize_reg, usize_next;
    logic [SW-1:0] k_reg, k_next;
    logic [SW-1:0] cidx_reg, cidx_next;
    logic          hsel_reg, hsel_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_W-1:0] val_reg, val_next;
    logic signed [SAMPLE_W-1:0] moved_reg, moved_next;
    logic signed [SAMPLE_W-1:0] child_reg, child_next;
    logic signed [MED_W-1:0]    med_reg, med_next;
    logic          rej_reg, rej_next;

    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [SAMPLE_W-1:0]  wr_data;
    logic [SAMPLE_W-1:0]  l_rdata;
    logic [SAMPLE_W-1:0]  u_rdata;
    logic signed [SAMPLE_W-1:0] rdata;

    logic                 cmp_max;
    logic signed [SAMPLE_W-1:0] cmp_a;
    logic signed [SAMPLE_W-1:0] cmp_b;
    logic                 cmp_out;

    logic          accept;
    logic [SW-1:0] l_eff;
    logic [SW-1:0] u_eff;
    logic [SW-1:0] cur_size;
    logic [SW-1:0] parent;
    logic [SW:0]   jl;
    logic [SW:0]   jr;
    logic [31:0]   total32;

    // Heap stores.
    rmh_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(SAMPLE_W)) u_lower_ram
    (
        .clk     (clk),
        .wr_en   (wr_en & hsel_reg),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (l_rdata)
    );

    rmh_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(SAMPLE_W)) u_upper_ram
    (
        .clk     (clk),
        .wr_en   (wr_en & ~hsel_reg),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (u_rdata)
    );

    // Shared compare unit.
    rmh_cmp u_cmp
    (
        .is_max   (cmp_max),
        .a        (cmp_a),
        .b        (cmp_b),
        .outranks (cmp_out)
    );

    // Handshake and derived indexes.
    assign accept   = samples.valid & samples.ready;
    assign samples.ready = (state_reg == S_IDLE);
    assign results.valid = (state_reg == S_OUT);
    assign results.median_doubled = med_reg;
    assign results.rejected = rej_reg;
    assign total32  = 32'(lsize_reg) + 32'(usize_reg);
    assign results.held_count = total32[CNT_W-1:0];

    assign l_eff    = samples.start_new ? '0 : lsize_reg;
    assign u_eff    = samples.start_new ? '0 : usize_reg;
    assign cur_size = hsel_reg ? lsize_reg : usize_reg;
    assign rdata    = hsel_reg ? $signed(l_rdata) : $signed(u_rdata);
    assign parent   = (k_reg - SW'(1)) >> 1;
    assign jl       = {k_reg, 1'b1};
    assign jr       = {k_reg, 1'b0} + (SW+1)'(2);

    // Compare operand selection.
    always_comb
    begin
        cmp_max = hsel_reg;
        cmp_a   = val_reg;
        cmp_b   = rdata;
        unique case (state_reg)
            S_TOPCMP:
            begin
                cmp_max = 1'b1;
                cmp_a   = x_reg;
                cmp_b   = $signed(l_rdata);
            end
            S_DNR:
            begin
                cmp_a = rdata;
                cmp_b = child_reg;
            end
            S_DNC:
            begin
                cmp_a = child_reg;
                cmp_b = val_reg;
            end
            default:
            begin
                cmp_a = val_reg;
                cmp_b = rdata;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_INS;
            lsize_reg <= '0;
            usize_reg <= '0;
            med_reg   <= '0;
            rej_reg   <= 1'b0;
            hsel_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            lsize_reg <= lsize_next;
            usize_reg <= usize_next;
            med_reg   <= med_next;
            rej_reg   <= rej_next;
            hsel_reg  <= hsel_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        cidx_reg  <= cidx_next;
        x_reg     <= x_next;
        val_reg   <= val_next;
        moved_reg <= moved_next;
        child_reg <= child_next;
    end

    // Sequencer: insert walks up, removal walks down, then the median.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        lsize_next = lsize_reg;
        usize_next = usize_reg;
        k_next     = k_reg;
        cidx_next  = cidx_reg;
        hsel_next  = hsel_reg;
        x_next     = x_reg;
        val_next   = val_reg;
        moved_next = moved_reg;
        child_next = child_reg;
        med_next   = med_reg;
        rej_next   = rej_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = k_reg[AW-1:0];
        wr_data    = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    lsize_next = l_eff;
                    usize_next = u_eff;
                    x_next     = samples.sample;
                    rej_next   = 1'b0;
                    phase_next = PH_INS;
                    if ((SW+1)'(l_eff) + (SW+1)'(u_eff) >= FULL_CNT)
                    begin
                        rej_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (l_eff == '0)
                    begin
                        hsel_next  = 1'b1;
                        val_next   = samples.sample;
                        k_next     = '0;
                        lsize_next = SW'(1);
                        state_next = S_UP;
                    end
                    else
                    begin
                        state_next = S_TOPCMP;
                    end
                end
            end
            S_TOPCMP:
            begin
                val_next = x_reg;
                if (!cmp_out)
                begin
                    hsel_next  = 1'b1;
                    k_next     = lsize_reg;
                    lsize_next = lsize_reg + SW'(1);
                end
                else
                begin
                    hsel_next  = 1'b0;
                    k_next     = usize_reg;
                    usize_next = usize_reg + SW'(1);
                end
                state_next = S_UP;
            end
            S_UP:
            begin
                if (k_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_AFTER;
                end
                else
                begin
                    rd_addr    = parent[AW-1:0];
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                wr_en = 1'b1;
                if (cmp_out)
                begin
                    wr_data    = rdata;
                    k_next     = parent;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_AFTER;
                end
            end
            S_AFTER:
            begin
                unique case (phase_reg)
                    PH_INS:
                    begin
                        if ((SW+1)'(lsize_reg) > (SW+1)'(usize_reg) + (SW+1)'(1))
                        begin
                            hsel_next  = 1'b1;
                            phase_next = PH_POP;
                            state_next = S_POP0;
                        end
                        else if ((SW+1)'(usize_reg) > (SW+1)'(lsize_reg) + (SW+1)'(1))
                        begin
                            hsel_next  = 1'b0;
                            phase_next = PH_POP;
                            state_next = S_POP0;
                        end
                        else
                        begin
                            state_next = S_MED;
                        end
                    end
                    PH_POP:
                    begin
                        hsel_next  = ~hsel_reg;
                        val_next   = moved_reg;
                        phase_next = PH_MOVE;
                        if (hsel_reg)
                        begin
                            k_next     = usize_reg;
                            usize_next = usize_reg + SW'(1);
                        end
                        else
                        begin
                            k_next     = lsize_reg;
                            lsize_next = lsize_reg + SW'(1);
                        end
                        state_next = S_UP;
                    end
                    default:
                    begin
                        state_next = S_MED;
                    end
                endcase
            end
            S_POP0:
            begin
                moved_next = rdata;
                rd_addr    = AW'(cur_size - SW'(1));
                if (hsel_reg)
                begin
                    lsize_next = lsize_reg - SW'(1);
                end
                else
                begin
                    usize_next = usize_reg - SW'(1);
                end
                state_next = S_POP1;
            end
            S_POP1:
            begin
                val_next   = rdata;
                k_next     = '0;
                state_next = S_DN;
            end
            S_DN:
            begin
                if (jl < (SW+1)'(cur_size))
                begin
                    rd_addr    = jl[AW-1:0];
                    state_next = S_DNL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_AFTER;
                end
            end
            S_DNL:
            begin
                child_next = rdata;
                cidx_next  = jl[SW-1:0];
                if (jr < (SW+1)'(cur_size))
                begin
                    rd_addr    = jr[AW-1:0];
                    state_next = S_DNR;
                end
                else
                begin
                    state_next = S_DNC;
                end
            end
            S_DNR:
            begin
                if (cmp_out)
                begin
                    child_next = rdata;
                    cidx_next  = jr[SW-1:0];
                end
                state_next = S_DNC;
            end
            S_DNC:
            begin
                wr_en = 1'b1;
                if (cmp_out)
                begin
                    wr_data    = child_reg;
                    k_next     = cidx_reg;
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_AFTER;
                end
            end
            S_MED:
            begin
                state_next = S_MED1;
            end
            S_MED1:
            begin
                if (lsize_reg == usize_reg)
                begin
                    med_next = MED_W'($signed(l_rdata)) + MED_W'($signed(u_rdata));
                end
                else if (lsize_reg > usize_reg)
                begin
                    med_next = {l_rdata, 1'b0};
                end
                else
                begin
                    med_next = {u_rdata, 1'b0};
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (results.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The heaps stay balanced between words.
    a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |->
            ((SW+1)'(lsize_reg) <= (SW+1)'(usize_reg) + (SW+1)'(1)) &&
            ((SW+1)'(usize_reg) <= (SW+1)'(lsize_reg) + (SW+1)'(1)))
        else $error("heap sizes out of balance");

    // A rejected word only comes from a full store.
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && rej_reg) |->
            ((SW+1)'(lsize_reg) + (SW+1)'(usize_reg) == FULL_CNT))
        else $error("word rejected with room left");

    // The insert hole always lies inside the heap.
    a_hole_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UP |-> k_reg < cur_size)
        else $error("insert walk outside the heap");

    // One word at a time: no new sample right after acceptance.
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !samples.ready)
        else $error("sample taken while busy");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Running median testbench
// Drives sample words into the two-heap median block and predicts each
// result with its own pair of heaps. Every result word is checked field by
// field against the oldest prediction, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb
    import rmh_pkg::*;
();

    localparam int DEPTH    = HEAP_DEPTH_DEF;
    localparam int CAPACITY = 2 * DEPTH - 1;

    typedef struct packed {
        logic signed [MED_W-1:0] median_doubled;
        logic [CNT_W-1:0]        held_count;
        logic                    rejected;
    } median_word_t;

    logic clk;
    logic rst_n;

    rmh_in_if  samples ();
    rmh_out_if results ();

    running_median_two_heaps DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results)
    );

    // Predicted heaps: max-heap for the lower half, min-heap for the upper.
    logic signed [31:0] low_heap [DEPTH];
    logic signed [31:0] high_heap [DEPTH];
    int unsigned        low_size;
    int unsigned        high_size;
    logic signed [33:0] last_median;

    median_word_t pending_medians [$];
    int           mismatch_count;
    bit           no_idle;
    int           hold_off_cycles;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Heap order: max-heap prefers larger, min-heap prefers smaller keys.
    function automatic bit ranks_above(bit is_max, logic signed [31:0] a,
                                       logic signed [31:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    function automatic void heap_insert(bit is_max, logic signed [31:0] v);
        int unsigned        k;
        int unsigned        p;
        logic signed [31:0] t;
        if (is_max)
        begin
            k = low_size;
            low_heap[k] = v;
            low_size++;
            while (k > 0)
            begin
                p = (k - 1) / 2;
                if (!ranks_above(1'b1, low_heap[k], low_heap[p]))
                    break;
                t = low_heap[k]; low_heap[k] = low_heap[p]; low_heap[p] = t;
                k = p;
            end
        end
        else
        begin
            k = high_size;
            high_heap[k] = v;
            high_size++;
            while (k > 0)
            begin
                p = (k - 1) / 2;
                if (!ranks_above(1'b0, high_heap[k], high_heap[p]))
                    break;
                t = high_heap[k]; high_heap[k] = high_heap[p]; high_heap[p] = t;
                k = p;
            end
        end
    endfunction

    function automatic logic signed [31:0] heap_take_top(bit is_max);
        int unsigned        n;
        int unsigned        k;
        int unsigned        j;
        logic signed [31:0] top;
        logic signed [31:0] t;
        k = 0;
        if (is_max)
        begin
            top = low_heap[0];
            n = low_size - 1;
            low_heap[0] = low_heap[n];
            low_size = n;
            while (2 * k + 1 < n)
            begin
                j = 2 * k + 1;
                if (j + 1 < n && ranks_above(1'b1, low_heap[j+1], low_heap[j]))
                    j++;
                if (!ranks_above(1'b1, low_heap[j], low_heap[k]))
                    break;
                t = low_heap[k]; low_heap[k] = low_heap[j]; low_heap[j] = t;
                k = j;
            end
        end
        else
        begin
            top = high_heap[0];
            n = high_size - 1;
            high_heap[0] = high_heap[n];
            high_size = n;
            while (2 * k + 1 < n)
            begin
                j = 2 * k + 1;
                if (j + 1 < n && ranks_above(1'b0, high_heap[j+1], high_heap[j]))
                    j++;
                if (!ranks_above(1'b0, high_heap[j], high_heap[k]))
                    break;
                t = high_heap[k]; high_heap[k] = high_heap[j]; high_heap[j] = t;
                k = j;
            end
        end
        return top;
    endfunction

    // Updates the predicted heaps with one accepted sample and returns the result.
    function automatic median_word_t predict_median(logic signed [31:0] x, bit restart);
        median_word_t w;
        w.rejected = 1'b0;
        if (restart)
        begin
            low_size  = 0;
            high_size = 0;
        end
        if (low_size + high_size >= CAPACITY)
            w.rejected = 1'b1;
        else
        begin
            if (low_size == 0 || x <= low_heap[0])
                heap_insert(1'b1, x);
            else
                heap_insert(1'b0, x);
            if (low_size > high_size + 1)
                heap_insert(1'b0, heap_take_top(1'b1));
            else if (high_size > low_size + 1)
                heap_insert(1'b1, heap_take_top(1'b0));
            if (low_size == high_size)
                last_median = 34'(low_heap[0]) + 34'(high_heap[0]);
            else if (low_size > high_size)
                last_median = 34'(low_heap[0]) * 2;
            else
                last_median = 34'(high_heap[0]) * 2;
        end
        w.median_doubled = last_median[MED_W-1:0];
        w.held_count     = CNT_W'(low_size + high_size);
        return w;
    endfunction

    // Sends one word; valid stays high after acceptance until the next decision.
    task automatic send_sample(logic signed [31:0] x, bit restart);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.valid     <= 1'b1;
        samples.sample    <= x;
        samples.start_new <= restart;
        do @(posedge clk); while (!samples.ready);
        pending_medians = {pending_medians, predict_median(x, restart)};
    endtask

    // Lowers valid and waits until every predicted word has arrived.
    task automatic wait_for_drain();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (pending_medians.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] random_sample();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 20)) - 10;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // Result receiver: random stalls, plus long hold-offs on request.
    initial
    begin
        int stall;
        results.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                results.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                results.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results.ready <= 1'b1;
            do @(posedge clk); while (!results.valid);
        end
    end

    // Result checker: compares each word with the oldest prediction.
    always @(posedge clk)
    begin
        median_word_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_medians.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result word: median_doubled=%0d held=%0d rej=%0b",
                             results.median_doubled, results.held_count, results.rejected);
            end
            else
            begin
                want = pending_medians.pop_front();
                if (results.median_doubled !== want.median_doubled ||
                    results.held_count !== want.held_count ||
                    results.rejected !== want.rejected)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected med=%0d held=%0d rej=%0b, got %0d %0d %0b",
                                 want.median_doubled, want.held_count, want.rejected,
                                 results.median_doubled, results.held_count,
                                 results.rejected);
                end
            end
        end
    end

    // Extremes of the sample range, ties, and restarts.
    task automatic test_directed();
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b1);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(0, 1'b1);
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(5, 1'b1);
        send_sample(4, 1'b0);
        send_sample(3, 1'b0);
        send_sample(2, 1'b0);
        send_sample(6, 1'b0);
        send_sample(7, 1'b0);
        send_sample(8, 1'b0);
        send_sample(32'sh55555555, 1'b1);
        send_sample(32'shaaaaaaaa, 1'b0);
        wait_for_drain();
    endtask

    // Fills the store to capacity, then checks that further samples are dropped.
    task automatic test_full_store();
        send_sample(random_sample(), 1'b1);
        for (int i = 1; i < CAPACITY + 5; i++)
        begin
            no_idle = (i / 128) % 3 == 1;
            send_sample(random_sample(), 1'b0);
        end
        no_idle = 1'b0;
        send_sample(random_sample(), 1'b1);
        wait_for_drain();
    endtask

    // Long receiver hold-off while samples keep being offered.
    task automatic test_backpressure();
        hold_off_cycles = 300;
        for (int i = 0; i < 10; i++)
            send_sample(random_sample(), i == 0);
        wait_for_drain();
    endtask

    // Random sequences of varying length with restarts.
    task automatic test_random_sequences();
        int len;
        for (int s = 0; s < 30; s++)
        begin
            len = $urandom_range(1, 16);
            no_idle = (s % 7) == 3;
            for (int i = 0; i < len; i++)
                send_sample(random_sample(), i == 0 || $urandom_range(0, 30) == 0);
        end
        no_idle = 1'b0;
        wait_for_drain();
    endtask

    initial
    begin
        mismatch_count  = 0;
        no_idle         = 1'b0;
        hold_off_cycles = 0;
        low_size        = 0;
        high_size       = 0;
        last_median     = '0;
        rst_n             = 1'b0;
        samples.valid     = 1'b0;
        samples.sample    = '0;
        samples.start_new = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_full_store();
        test_random_sequences();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && pending_medians.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit.
    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
rtl/rmh_pkg.sv
rtl/rmh_in_if.sv
rtl/rmh_out_if.sv
rtl/rmh_ram.sv
rtl/rmh_cmp.sv
rtl/running_median_two_heaps.sv
dv/tb.sv
